[hw/rtl/irpde_pkg.sv]
// ----------------------------------------------------------------------------
// irpde_pkg
// Shared types and constants for the IR pulse-distance frame encoder.
// ----------------------------------------------------------------------------
package irpde_pkg;

  localparam int PayloadW    = 8;                   // width of the input field
  localparam int PayloadBits = 8;                   // data bits sent per frame
  localparam int DurW        = 16;                  // segment length width
  localparam int RegIdxW     = 3;
  localparam int NumSegs     = 2 * PayloadBits + 3; // header x2, bits x2, stop
  localparam int SegCntW     = $clog2(NumSegs);
  localparam int QDepth      = 2;                   // depth of each word queue
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  typedef enum logic [RegIdxW-1:0] {
    RegHeaderMark  = 3'd0,
    RegHeaderSpace = 3'd1,
    RegBitMark     = 3'd2,
    RegZeroSpace   = 3'd3,
    RegOneSpace    = 3'd4,
    RegStopMark    = 3'd5
  } reg_idx_e;

  typedef logic [PayloadBits-1:0] word_t;

  typedef struct packed {
    logic [DurW-1:0] header_mark_us;
    logic [DurW-1:0] header_space_us;
    logic [DurW-1:0] bit_mark_us;
    logic [DurW-1:0] zero_space_us;
    logic [DurW-1:0] one_space_us;
    logic [DurW-1:0] stop_mark_us;
  } timing_t;

  typedef struct packed {
    logic            carrier_on;
    logic [DurW-1:0] segment_us;
    logic            last_segment;
  } seg_t;

  localparam timing_t TimingRst = '{
    header_mark_us:  16'd9000,
    header_space_us: 16'd4500,
    bit_mark_us:     16'd560,
    zero_space_us:   16'd560,
    one_space_us:    16'd1690,
    stop_mark_us:    16'd560
  };

endpackage

[hw/rtl/irpde_in_queue.sv]
// ----------------------------------------------------------------------------
// irpde_in_queue
// Front end: accepts payload words, widens them to frame width, and queues
// them for the segment sequencer.
// ----------------------------------------------------------------------------
module irpde_in_queue import irpde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [PayloadW-1:0] payload_i,
  input  logic                deq_i,
  output logic                avail_o,
  output word_t               word_o
);

  word_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             wr_en, rd_en;

  // upper frame bits beyond the field go out as zeros, extra field bits drop
  word_t word_in;
  assign word_in = word_t'(payload_i);

  assign full    = (cnt_q == QCntW'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign wr_en   = push && !full;
  assign rd_en   = deq_i && avail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= word_in;
  end

endmodule

[hw/rtl/irpde_seq.sv]
// ----------------------------------------------------------------------------
// irpde_seq
// Back end: walks one frame per word, one segment per cycle while the result
// queue is ready, shifting the word out most significant bit first.
// ----------------------------------------------------------------------------
module irpde_seq import irpde_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  word_t   word_i,
  output logic    deq_o,
  input  timing_t timing_i,
  input  logic    out_ready_i,
  output logic    seg_valid_o,
  output seg_t    seg_o
);

  localparam logic [SegCntW-1:0] LastCnt = SegCntW'(NumSegs - 1);
  localparam logic [SegCntW-1:0] HdrSpaceCnt = SegCntW'(1);

  logic               busy_q;
  logic [SegCntW-1:0] cnt_q;
  word_t              word_q;
  logic               step, last, load;

  assign step        = busy_q && out_ready_i;
  assign last        = step && (cnt_q == LastCnt);
  assign load        = avail_i && (!busy_q || last);
  assign deq_o       = load;
  assign seg_valid_o = step;

  always_comb begin
    seg_o = '0;
    if (cnt_q == '0) begin
      seg_o.carrier_on = 1'b1;
      seg_o.segment_us = timing_i.header_mark_us;
    end else if (cnt_q == HdrSpaceCnt) begin
      seg_o.segment_us = timing_i.header_space_us;
    end else if (cnt_q == LastCnt) begin
      seg_o.carrier_on   = 1'b1;
      seg_o.segment_us   = timing_i.stop_mark_us;
      seg_o.last_segment = 1'b1;
    end else if (!cnt_q[0]) begin
      seg_o.carrier_on = 1'b1;
      seg_o.segment_us = timing_i.bit_mark_us;
    end else begin
      seg_o.segment_us = word_q[PayloadBits-1] ? timing_i.one_space_us
                                               : timing_i.zero_space_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (last) begin
      busy_q <= 1'b0;
    end else if (step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // next bit moves up after each data space
  always_ff @(posedge clk_i) begin
    if (load) word_q <= word_i;
    else if (step && cnt_q[0] && cnt_q != HdrSpaceCnt && !last)
      word_q <= word_q << 1;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= LastCnt))
    else $error("segment counter past end of frame");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_ready_i) |=> (busy_q && $stable(cnt_q)))
    else $error("sequencer advanced while output stalled");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last && !avail_i) |=> !busy_q)
    else $error("sequencer still busy after stop mark");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (busy_q && cnt_q == '0))
    else $error("new frame did not start at header mark");
`endif

endmodule

[hw/rtl/irpde_out_queue.sv]
// ----------------------------------------------------------------------------
// irpde_out_queue
// Two-entry result queue between the sequencer and the consumer.
// ----------------------------------------------------------------------------
module irpde_out_queue import irpde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  seg_t seg_i,
  output logic out_ready_o,
  input  logic pop,
  output logic empty,
  output seg_t seg_o
);

  seg_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             wr_en, rd_en;

  assign empty       = (cnt_q == '0);
  assign rd_en       = pop && !empty;
  // a full queue still takes a word when the head leaves in the same cycle
  assign out_ready_o = (cnt_q != QCntW'(QDepth)) || rd_en;
  assign wr_en       = push_i && out_ready_o;
  assign seg_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= seg_i;
  end

endmodule

[hw/rtl/ir_pulse_distance_encoder.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder
// Turns each payload byte into a pulse-distance IR frame: header mark and
// space, a mark and a short or long space per bit (MSB first), a stop mark.
//
//   channel  direction  handshake           payload
//   input    in         push / full         payload_i
//   result   out        pop / empty         carrier_on_o, segment_us_o,
//                                           last_segment_o
//   config   in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// One segment per cycle from the sequencer when results are popped without
// stall, 19 segments per word. A word passes the input queue, sequencer and
// result queue, each registered, before its first segment shows up.
// The input queue holds 2 words, the result queue 2 segments; a stalled pop
// freezes the sequencer while the input side keeps filling.
// Reset restores default timings and empties both queues.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder import irpde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [PayloadW-1:0] payload_i,
  output logic                empty,
  input  logic                pop,
  output logic                carrier_on_o,
  output logic [DurW-1:0]     segment_us_o,
  output logic                last_segment_o,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [DurW-1:0]     cfg_data_i
);

  timing_t timing_q;
  logic    avail, deq, out_ready, seg_valid;
  word_t   word;
  seg_t    seg, seg_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q <= TimingRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegHeaderMark:  timing_q.header_mark_us  <= cfg_data_i;
        RegHeaderSpace: timing_q.header_space_us <= cfg_data_i;
        RegBitMark:     timing_q.bit_mark_us     <= cfg_data_i;
        RegZeroSpace:   timing_q.zero_space_us   <= cfg_data_i;
        RegOneSpace:    timing_q.one_space_us    <= cfg_data_i;
        RegStopMark:    timing_q.stop_mark_us    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  irpde_in_queue u_in_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .payload_i (payload_i),
    .deq_i     (deq),
    .avail_o   (avail),
    .word_o    (word)
  );

  irpde_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .word_i      (word),
    .deq_o       (deq),
    .timing_i    (timing_q),
    .out_ready_i (out_ready),
    .seg_valid_o (seg_valid),
    .seg_o       (seg)
  );

  irpde_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (seg_valid),
    .seg_i       (seg),
    .out_ready_o (out_ready),
    .pop         (pop),
    .empty       (empty),
    .seg_o       (seg_out)
  );

  assign carrier_on_o   = seg_out.carrier_on;
  assign segment_us_o   = seg_out.segment_us;
  assign last_segment_o = seg_out.last_segment;

endmodule
